FILE: sv/purchase_overlap_nearest_client_unit_macros.svh
// Assertion helpers for the top-level RTL file.
// Both sample on clk and are switched off while rst_n is low.
`ifndef PURCHASE_OVERLAP_NEAREST_CLIENT_UNIT_MACROS_SVH
`define PURCHASE_OVERLAP_NEAREST_CLIENT_UNIT_MACROS_SVH

// same-cycle implication
`define PONC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PONC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ponc_pkg.sv
package ponc_pkg;

  localparam int NUM_CLIENTS  = 64;
  localparam int NUM_PRODUCTS = 256;
  localparam int CLIENT_W     = 6;
  localparam int PRODUCT_W    = 8;
  localparam int COUNT_W      = 9;
  localparam int CC_W         = 7;
  localparam int PC_W         = 9;
  localparam int CFG_DATA_W   = 9;
  localparam int CFG_IDX_W    = 1;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_NEAREST = 2'd2;
  localparam logic [1:0] CMD_PAIR    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]           command;
    logic [CLIENT_W-1:0]  client;
    logic [CLIENT_W-1:0]  other_client;
    logic [PRODUCT_W-1:0] product;
  } in_item_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] match_client;
    logic [COUNT_W-1:0]  shared_count;
    logic [COUNT_W-1:0]  own_count;
    logic                has_match;
    logic                status;
  } out_item_t;

  // single-port request to the purchase store
  typedef struct packed {
    logic                   rd_en;
    logic                   wr_en;
    logic [PRODUCT_W-1:0]   addr;
    logic [NUM_CLIENTS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic clr;
    logic acc;
    logic shift;
  } lane_ctl_t;

endpackage

FILE: sv/ponc_store.sv
module ponc_store (
  input  logic                             clk,
  input  ponc_pkg::mem_req_t               req,
  output logic [ponc_pkg::NUM_CLIENTS-1:0] rd_data
);

  // one row per product, one bit per client
  logic [ponc_pkg::NUM_CLIENTS-1:0] mem_r [0:ponc_pkg::NUM_PRODUCTS-1];
  logic [ponc_pkg::NUM_CLIENTS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/ponc_lanes.sv
module ponc_lanes (
  input  logic                             clk,
  input  ponc_pkg::lane_ctl_t              ctl,
  input  logic [ponc_pkg::NUM_CLIENTS-1:0] mask,
  output logic [ponc_pkg::COUNT_W-1:0]     head
);

  // per-client overlap counters; shifted towards lane 0 for the scan
  logic [ponc_pkg::COUNT_W-1:0] cnt_r [0:ponc_pkg::NUM_CLIENTS-1];

  for (genvar i = 0; i < ponc_pkg::NUM_CLIENTS; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (ctl.clr) begin
        cnt_r[i] <= '0;
      end else if (ctl.acc) begin
        cnt_r[i] <= cnt_r[i] + ponc_pkg::COUNT_W'(mask[i]);
      end else if (ctl.shift) begin
        if (i == ponc_pkg::NUM_CLIENTS - 1) begin
          cnt_r[i] <= '0;
        end else begin
          cnt_r[i] <= cnt_r[(i + 1) % ponc_pkg::NUM_CLIENTS];
        end
      end
    end
  end

  assign head = cnt_r[0];

endmodule

FILE: sv/purchase_overlap_nearest_client_unit.sv
// Nearest and pair queries: a pass over all 256 product rows builds every client's overlap,
// then a scan through one compare unit gives the result. Add purchase: row read, row write,
// result. Clear: a sweep over all rows, then the result; rejected items go straight to the result.
// The next item is taken the cycle after the result is loaded, even while it waits; a result
// still waiting holds the following item in its last cycle.
// rst_n (synchronous, active low): clearing sweep over all rows, no item taken; limits 64 / 256.
`include "purchase_overlap_nearest_client_unit_macros.svh"

module purchase_overlap_nearest_client_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ponc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ponc_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [ponc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ponc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam int NC = ponc_pkg::NUM_CLIENTS;
  localparam int CW = ponc_pkg::CLIENT_W;
  localparam int KW = ponc_pkg::COUNT_W;

  logic [2:0]                  state_r, state_nxt;
  logic [ponc_pkg::CC_W-1:0]   cc_r;
  logic [ponc_pkg::PC_W-1:0]   pc_r;
  logic [1:0]                  cmd_r;
  logic [CW-1:0]               c_r, o_r;
  logic [ponc_pkg::PRODUCT_W-1:0] prod_r;
  logic                        bad_r;
  logic                        clr_res_r;
  logic [ponc_pkg::PRODUCT_W:0] p_r;
  logic                        rdv_r;
  logic [CW-1:0]               j_r;
  logic [KW-1:0]               best_r, own_r, pair_r;
  logic [CW-1:0]               bestj_r, fb_r;
  logic                        found_r, fbv_r;
  logic                        out_valid_r;
  ponc_pkg::out_item_t         out_data_r;

  ponc_pkg::mem_req_t          req;
  ponc_pkg::lane_ctl_t         lctl;
  ponc_pkg::out_item_t         res;
  logic [NC-1:0]               rd_data, mask;
  logic [KW-1:0]               head;
  logic [ponc_pkg::CC_W-1:0]   nc;
  logic [ponc_pkg::PC_W-1:0]   np;
  logic                        accept, c_bad, o_bad, p_bad, in_bad, fin_load, in_set;

  ponc_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  ponc_lanes u_lanes (
    .clk  (clk),
    .ctl  (lctl),
    .mask (mask),
    .head (head)
  );

  // effective limits
  assign nc = (cc_r > ponc_pkg::CC_W'(NC)) ? ponc_pkg::CC_W'(NC) : cc_r;
  assign np = (pc_r > ponc_pkg::PC_W'(ponc_pkg::NUM_PRODUCTS)) ?
              ponc_pkg::PC_W'(ponc_pkg::NUM_PRODUCTS) : pc_r;

  assign c_bad = {1'b0, in_data.client} >= nc;
  assign o_bad = {1'b0, in_data.other_client} >= nc;
  assign p_bad = {1'b0, in_data.product} >= np;

  always_comb begin
    case (in_data.command)
      ponc_pkg::CMD_CLEAR:   in_bad = 1'b0;
      ponc_pkg::CMD_ADD:     in_bad = c_bad || p_bad;
      ponc_pkg::CMD_NEAREST: in_bad = c_bad;
      ponc_pkg::CMD_PAIR:    in_bad = c_bad || o_bad;
      default:               in_bad = 1'b0;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // only rows where the queried client bought count towards the overlaps
  assign mask = rd_data & {NC{rd_data[c_r]}};

  assign in_set = ({1'b0, j_r} < nc) && (j_r != c_r);

  always_comb begin
    state_nxt = state_r;
    req       = '0;
    lctl      = '0;
    case (state_r)
      S_CLEAR: begin
        req.wr_en = 1'b1;
        req.addr  = p_r[ponc_pkg::PRODUCT_W-1:0];
        if (p_r[ponc_pkg::PRODUCT_W-1:0] == '1) begin
          state_nxt = clr_res_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_bad) begin
            state_nxt = S_FIN;
          end else begin
            case (in_data.command)
              ponc_pkg::CMD_CLEAR: state_nxt = S_CLEAR;
              ponc_pkg::CMD_ADD: begin
                req.rd_en = 1'b1;
                req.addr  = in_data.product;
                state_nxt = S_ADD;
              end
              default: begin
                lctl.clr  = 1'b1;
                state_nxt = S_ACC;
              end
            endcase
          end
        end
      end
      S_ADD: begin
        req.wr_en = 1'b1;
        req.addr  = prod_r;
        req.wdata = rd_data | (NC'(1) << c_r);
        state_nxt = S_FIN;
      end
      S_ACC: begin
        if (!p_r[ponc_pkg::PRODUCT_W]) begin
          req.rd_en = 1'b1;
          req.addr  = p_r[ponc_pkg::PRODUCT_W-1:0];
        end
        lctl.acc = rdv_r;
        if (p_r[ponc_pkg::PRODUCT_W] && !rdv_r) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        lctl.shift = 1'b1;
        if (j_r == '1) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    if (bad_r) begin
      res.status = 1'b1;
    end else begin
      case (cmd_r)
        ponc_pkg::CMD_NEAREST: begin
          res.own_count = own_r;
          if (found_r) begin
            res.match_client = bestj_r;
            res.shared_count = best_r;
            res.has_match    = 1'b1;
          end else if (fbv_r) begin
            res.match_client = fb_r;
            res.has_match    = 1'b1;
          end
        end
        ponc_pkg::CMD_PAIR: begin
          res.match_client = o_r;
          res.shared_count = pair_r;
          res.own_count    = own_r;
          res.has_match    = 1'b1;
        end
        default: res = '0;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      p_r         <= '0;
      rdv_r       <= 1'b0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cc_r        <= ponc_pkg::CC_W'(64);
      pc_r        <= ponc_pkg::PC_W'(256);
    end else begin
      state_r <= state_nxt;
      rdv_r   <= (state_r == S_ACC) && !p_r[ponc_pkg::PRODUCT_W];
      if (accept) begin
        p_r       <= '0;
        clr_res_r <= 1'b1;
      end else if (state_r == S_CLEAR ||
                   (state_r == S_ACC && !p_r[ponc_pkg::PRODUCT_W])) begin
        p_r <= p_r + 1'b1;
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          ponc_pkg::CFG_CLIENT_COUNT:  cc_r <= cfg_wdata[ponc_pkg::CC_W-1:0];
          ponc_pkg::CFG_PRODUCT_COUNT: pc_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // item fields and the shared compare unit
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_data.command;
      c_r     <= in_data.client;
      o_r     <= in_data.other_client;
      prod_r  <= in_data.product;
      bad_r   <= in_bad;
      j_r     <= '0;
      best_r  <= '0;
      found_r <= 1'b0;
      fbv_r   <= 1'b0;
    end else if (state_r == S_SCAN) begin
      j_r <= j_r + 1'b1;
      if (in_set && head > best_r) begin
        best_r  <= head;
        bestj_r <= j_r;
        found_r <= 1'b1;
      end
      // first other client in range, used when nobody shares anything
      if (in_set && !fbv_r) begin
        fb_r  <= j_r;
        fbv_r <= 1'b1;
      end
      if (j_r == c_r) begin
        own_r <= head;
      end
      if (j_r == o_r) begin
        pair_r <= head;
      end
    end
    if (fin_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PONC_ASSERT_NXT(a_accept_leaves_idle, accept, state_r != S_IDLE,
                   "idle after accepting an item")
  `PONC_ASSERT_IMP(a_scan_no_acc, state_r == S_SCAN, !rdv_r, "row accumulate during scan")
  `PONC_ASSERT_IMP(a_reject_zero, out_valid_r && out_data_r.status,
                   out_data_r.match_client == '0 && out_data_r.shared_count == '0 &&
                   out_data_r.own_count == '0 && !out_data_r.has_match,
                   "rejected item with nonzero fields")
  `PONC_ASSERT_IMP(a_shared_le_own, out_valid_r,
                   out_data_r.shared_count <= out_data_r.own_count,
                   "shared count above own count")

endmodule

FILE: verif/purchase_overlap_nearest_client_unit_tb.sv
`timescale 1ns / 100ps

module purchase_overlap_nearest_client_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 1500;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 60;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  ponc_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  ponc_pkg::out_item_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [ponc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ponc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the purchase store and the two limit registers
  logic [ponc_pkg::NUM_CLIENTS-1:0] purchase_rows [ponc_pkg::NUM_PRODUCTS];
  logic [ponc_pkg::CC_W-1:0]        model_clients;
  logic [ponc_pkg::PC_W-1:0]        model_products;

  ponc_pkg::in_item_t  queued_requests [$];
  ponc_pkg::out_item_t pending_answers [$];

  int offered_items   = 0;
  int taken_items     = 0;
  int answered_items  = 0;
  int counted_answers = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;
  int send_gap        = 0;
  int recv_wait       = 0;
  int hold_left       = 0;
  bit sender_idles    = 1'b1;
  bit receiver_idles  = 1'b1;
  bit hold_req        = 1'b0;
  bit hold_seen       = 1'b0;

  int phase_clients  [PHASES] = '{64, 127, 8, 2, 1, 0, 33, 64};
  int phase_products [PHASES] = '{256, 511, 16, 256, 40, 0, 200, 1};

  purchase_overlap_nearest_client_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int shared_products(int a, int b);
    int n;
    n = 0;
    for (int p = 0; p < ponc_pkg::NUM_PRODUCTS; p++)
      if (purchase_rows[p][a] && purchase_rows[p][b]) n++;
    return n;
  endfunction

  // updates the shadow store and returns the answer the block owes for req
  function automatic ponc_pkg::out_item_t predict_client_answer(ponc_pkg::in_item_t req);
    ponc_pkg::out_item_t ans;
    int                  nc;
    int                  np;
    int                  best;
    int                  s;
    bit                  found;
    ans   = '0;
    best  = 0;
    found = 1'b0;
    nc = (model_clients > ponc_pkg::NUM_CLIENTS) ? ponc_pkg::NUM_CLIENTS
                                                 : int'(model_clients);
    np = (model_products > ponc_pkg::NUM_PRODUCTS) ? ponc_pkg::NUM_PRODUCTS
                                                   : int'(model_products);
    case (req.command)
      ponc_pkg::CMD_CLEAR: begin
        for (int p = 0; p < ponc_pkg::NUM_PRODUCTS; p++) purchase_rows[p] = '0;
      end
      ponc_pkg::CMD_ADD: begin
        if (req.client >= nc || req.product >= np) ans.status = 1'b1;
        else purchase_rows[req.product][req.client] = 1'b1;
      end
      ponc_pkg::CMD_NEAREST: begin
        if (req.client >= nc) begin
          ans.status = 1'b1;
        end else begin
          ans.own_count = ponc_pkg::COUNT_W'(shared_products(req.client, req.client));
          for (int j = 0; j < nc; j++) begin
            if (j != req.client) begin
              s = shared_products(req.client, j);
              if (s > best) begin
                best             = s;
                ans.match_client = ponc_pkg::CLIENT_W'(j);
                found            = 1'b1;
              end
            end
          end
          if (found) begin
            ans.shared_count = ponc_pkg::COUNT_W'(best);
            ans.has_match    = 1'b1;
          end else begin
            // no overlap anywhere: fall back to the lowest other index
            for (int j = 0; j < nc; j++) begin
              if (j != req.client && !ans.has_match) begin
                ans.match_client = ponc_pkg::CLIENT_W'(j);
                ans.has_match    = 1'b1;
              end
            end
          end
        end
      end
      ponc_pkg::CMD_PAIR: begin
        if (req.client >= nc || req.other_client >= nc) begin
          ans.status = 1'b1;
        end else begin
          ans.own_count    = ponc_pkg::COUNT_W'(shared_products(req.client, req.client));
          ans.shared_count = ponc_pkg::COUNT_W'(shared_products(req.client,
                                                                req.other_client));
          ans.match_client = req.other_client;
          ans.has_match    = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result check before taking the new item, so a stray result cannot pair with it
  always @(posedge clk) begin
    ponc_pkg::out_item_t want;
    ponc_pkg::out_item_t owed;
    bit                  moved;
    moved = 1'b0;
    if (!rst_n) begin
      for (int p = 0; p < ponc_pkg::NUM_PRODUCTS; p++) purchase_rows[p] = '0;
      model_clients  = ponc_pkg::CC_W'(ponc_pkg::NUM_CLIENTS);
      model_products = ponc_pkg::PC_W'(ponc_pkg::NUM_PRODUCTS);
    end else begin
      if (cfg_we) begin
        if (cfg_index == ponc_pkg::CFG_CLIENT_COUNT) begin
          model_clients = cfg_wdata[ponc_pkg::CC_W-1:0];
        end else begin
          model_products = cfg_wdata[ponc_pkg::PC_W-1:0];
        end
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        answered_items++;
        if (pending_answers.size() == 0) begin
          $error("result with nothing outstanding: %p", out_data);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          check_field("match_client", 16'(want.match_client), 16'(out_data.match_client));
          check_field("shared_count", 16'(want.shared_count), 16'(out_data.shared_count));
          check_field("own_count", 16'(want.own_count), 16'(out_data.own_count));
          check_field("has_match", 16'(want.has_match), 16'(out_data.has_match));
          check_field("status", 16'(want.status), 16'(out_data.status));
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        taken_items++;
        owed = predict_client_answer(in_data);
        pending_answers = {pending_answers, owed};
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (taken_items == offered_items) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          in_data  <= queued_requests.pop_front();
          in_valid <= 1'b1;
          offered_items++;
          send_gap = sender_idles ? $urandom_range(0, 3) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (answered_items != counted_answers) begin
        counted_answers = answered_items;
        recv_wait = receiver_idles ? $urandom_range(0, 3) : 0;
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_request(logic [1:0] cmd, int client, int other, int product);
    ponc_pkg::in_item_t req;
    req.command      = cmd;
    req.client       = ponc_pkg::CLIENT_W'(client);
    req.other_client = ponc_pkg::CLIENT_W'(other);
    req.product      = ponc_pkg::PRODUCT_W'(product);
    queued_requests  = {queued_requests, req};
  endtask

  // mostly purchases and queries among a few clients and products, so overlaps build up
  function automatic ponc_pkg::in_item_t random_request(int focus);
    ponc_pkg::in_item_t req;
    int                 r;
    r = $urandom_range(0, 99);
    req.command = (r < 2)  ? ponc_pkg::CMD_CLEAR :
                  (r < 55) ? ponc_pkg::CMD_ADD :
                  (r < 75) ? ponc_pkg::CMD_NEAREST : ponc_pkg::CMD_PAIR;
    req.client = ($urandom_range(0, 9) < 7) ?
                 ponc_pkg::CLIENT_W'($urandom_range(0, focus)) :
                 ponc_pkg::CLIENT_W'($urandom_range(0, ponc_pkg::NUM_CLIENTS - 1));
    req.other_client = ($urandom_range(0, 9) < 7) ?
                       ponc_pkg::CLIENT_W'($urandom_range(0, focus)) :
                       ponc_pkg::CLIENT_W'($urandom_range(0, ponc_pkg::NUM_CLIENTS - 1));
    req.product = ($urandom_range(0, 9) < 7) ?
                  ponc_pkg::PRODUCT_W'($urandom_range(0, 15)) :
                  ponc_pkg::PRODUCT_W'($urandom_range(0, ponc_pkg::NUM_PRODUCTS - 1));
    return req;
  endfunction

  task automatic wait_idle();
    while (queued_requests.size() != 0 || taken_items != offered_items ||
           pending_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [ponc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ponc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // spare upper bits of the client count write are filled at random
  task automatic set_limits(int clients, int products);
    write_reg(ponc_pkg::CFG_CLIENT_COUNT,
              ponc_pkg::CFG_DATA_W'(clients) |
              (ponc_pkg::CFG_DATA_W'($urandom_range(0, 3)) << ponc_pkg::CC_W));
    write_reg(ponc_pkg::CFG_PRODUCT_COUNT, ponc_pkg::CFG_DATA_W'(products));
  endtask

  initial begin
    int                 eff;
    int                 focus;
    ponc_pkg::in_item_t fresh;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default limits: repeats, extremes, self pair, nearest with and without overlap
    push_request(ponc_pkg::CMD_CLEAR, 0, 0, 0);
    push_request(ponc_pkg::CMD_ADD, 0, 0, 0);
    push_request(ponc_pkg::CMD_ADD, 0, 0, 0);
    push_request(ponc_pkg::CMD_ADD, 0, 0, 255);
    push_request(ponc_pkg::CMD_ADD, 63, 0, 255);
    push_request(ponc_pkg::CMD_ADD, 63, 0, 0);
    push_request(ponc_pkg::CMD_ADD, 1, 0, 0);
    push_request(ponc_pkg::CMD_PAIR, 0, 63, 0);
    push_request(ponc_pkg::CMD_PAIR, 5, 5, 0);
    push_request(ponc_pkg::CMD_PAIR, 0, 0, 0);
    push_request(ponc_pkg::CMD_NEAREST, 0, 0, 0);
    push_request(ponc_pkg::CMD_NEAREST, 5, 0, 0);
    push_request(ponc_pkg::CMD_NEAREST, 63, 0, 0);
    wait_idle();

    // lowered limits: rejects, recorded bits kept beyond the limits
    set_limits(2, 1);
    push_request(ponc_pkg::CMD_ADD, 1, 0, 1);
    push_request(ponc_pkg::CMD_ADD, 2, 0, 0);
    push_request(ponc_pkg::CMD_PAIR, 0, 63, 0);
    push_request(ponc_pkg::CMD_NEAREST, 0, 0, 0);
    wait_idle();
    set_limits(1, 1);
    push_request(ponc_pkg::CMD_NEAREST, 0, 0, 0);
    wait_idle();
    set_limits(0, 0);
    push_request(ponc_pkg::CMD_ADD, 0, 0, 0);
    push_request(ponc_pkg::CMD_PAIR, 0, 0, 0);
    push_request(ponc_pkg::CMD_CLEAR, 0, 0, 0);
    wait_idle();
    set_limits(127, 511);
    push_request(ponc_pkg::CMD_PAIR, 63, 0, 0);
    push_request(ponc_pkg::CMD_ADD, 63, 63, 255);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      set_limits(phase_clients[ph], phase_products[ph]);
      sender_idles   = (ph % 3) != 2;
      receiver_idles = (ph % 4) != 3;
      eff   = (phase_clients[ph] > ponc_pkg::NUM_CLIENTS) ? ponc_pkg::NUM_CLIENTS
                                                          : phase_clients[ph];
      focus = (eff > 1) ? $urandom_range(1, (eff - 1 < 12) ? eff - 1 : 12) : 1;
      if (ph == 0) begin
        // long receiver stall while items keep coming, so the input backs up
        @(posedge clk);
        hold_req = ~hold_req;
      end
      for (int k = 0; k < PHASE_ITEMS / 2; k++) begin
        fresh           = random_request(focus);
        queued_requests = {queued_requests, fresh};
      end
      if (ph == 1) wait_idle();
      for (int k = 0; k < PHASE_ITEMS / 2; k++) begin
        fresh           = random_request(focus);
        queued_requests = {queued_requests, fresh};
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
